### rtl/bam_layer_multiplexer_macros.svh
// ----------------------------------------------------------------------------
// LED cube layer multiplexer: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BAM_LAYER_MULTIPLEXER_MACROS_SVH
`define BAM_LAYER_MULTIPLEXER_MACROS_SVH

// Same-cycle implication, off during reset.
`define BAM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define BAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after a reset cycle.
`define BAM_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### rtl/bam_pkg.sv
// ----------------------------------------------------------------------------
// LED cube layer multiplexer: package
// Defaults, codes, command type and helpers shared by the front and back.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int LAYERS_DEF            = 4;
  localparam int BYTES_PER_LAYER_N_DEF = 2;
  localparam int SLOT_WRAP_DEF         = 16;

  localparam int PLANE_COUNT = 4;
  // A write index is three bits wide, so only the first eight bytes of a
  // plane can ever hold anything but zero.
  localparam int STORE_BYTES = 8;
  localparam int MEM_DEPTH   = PLANE_COUNT * STORE_BYTES;
  localparam int MEM_ADDR_W  = $clog2(MEM_DEPTH);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } bam_action_t;

  typedef enum logic {
    B_IDLE,
    B_TICK
  } bam_back_state_t;

  typedef struct packed {
    logic       is_tick;
    logic [1:0] plane;
    logic [2:0] wr_index;
    logic [7:0] wr_value;
    logic [3:0] onehot;
  } bam_cmd_t;

  // Width of a byte position within a plane, wide enough to compare with
  // the eight stored bytes as well.
  function automatic int bam_idx_w(input int plane_bytes);
    int w;
    w = $clog2(plane_bytes);
    return (w < 3) ? 4 : w + 1;
  endfunction

  // Weight of a slot: plane 3 for 8 and up, 2 for 4..7, 1 for 2..3, else 0.
  function automatic logic [1:0] bam_pick_plane(input logic [3:0] slot);
    logic [1:0] p;
    if (slot > 4'd7) begin
      p = 2'd3;
    end else if (slot > 4'd3) begin
      p = 2'd2;
    end else if (slot > 4'd1) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

endpackage

### rtl/bam_layer_multiplexer.sv
// ----------------------------------------------------------------------------
// Path: a tick passes the front queue, the back end's B_TICK state and the output register.
// Flow: the back end finishes a write or a tick's BYTES_PER_LAYER_N bytes before the
// next command; the front takes an item per cycle while its 2-deep queue has room.
// Reset: frame store reads as zero, layer 0, slot 1, queue and output empty.
// ----------------------------------------------------------------------------
module bam_layer_multiplexer
  import bam_pkg::*;
#(
  parameter int LAYERS            = LAYERS_DEF,
  parameter int BYTES_PER_LAYER_N = BYTES_PER_LAYER_N_DEF,
  parameter int SLOT_WRAP         = SLOT_WRAP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [1:0] plane,
  input  logic [2:0] byte_index,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] shift_byte,
  output logic [3:0] layer_onehot,
  output logic [1:0] shown_plane,
  output logic       last
);

  localparam int IDX_W = bam_idx_w(LAYERS * BYTES_PER_LAYER_N);

  logic             q_valid;
  bam_cmd_t         q_cmd;
  logic [IDX_W-1:0] q_base;
  logic             q_pop;

  bam_front #(
    .LAYERS            (LAYERS),
    .BYTES_PER_LAYER_N (BYTES_PER_LAYER_N),
    .SLOT_WRAP         (SLOT_WRAP),
    .IDX_W             (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .plane      (plane),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_base     (q_base),
    .q_pop      (q_pop)
  );

  bam_back #(
    .BYTES_PER_LAYER_N (BYTES_PER_LAYER_N),
    .IDX_W             (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_base       (q_base),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .shift_byte   (shift_byte),
    .layer_onehot (layer_onehot),
    .shown_plane  (shown_plane),
    .last         (last)
  );

endmodule

### rtl/bam_front.sv
// ----------------------------------------------------------------------------
// LED cube layer multiplexer: front end
// Accepts items, drops writes outside the plane, stamps ticks with layer
// and plane from the refresh counters, and queues commands for the back end.
// ----------------------------------------------------------------------------
module bam_front
  import bam_pkg::*;
#(
  parameter int LAYERS            = LAYERS_DEF,
  parameter int BYTES_PER_LAYER_N = BYTES_PER_LAYER_N_DEF,
  parameter int SLOT_WRAP         = SLOT_WRAP_DEF,
  parameter int IDX_W             = bam_idx_w(LAYERS * BYTES_PER_LAYER_N)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             action,
  input  logic [1:0]       plane,
  input  logic [2:0]       byte_index,
  input  logic [7:0]       byte_value,
  output logic             q_valid,
  output bam_cmd_t         q_cmd,
  output logic [IDX_W-1:0] q_base,
  input  logic             q_pop
);

  localparam int LAYER_W     = $clog2(LAYERS);
  localparam int PLANE_BYTES = LAYERS * BYTES_PER_LAYER_N;
  localparam int Q_DEPTH     = 2;

  logic [LAYER_W-1:0] layer_count;
  logic [3:0]         slot_count;

  bam_cmd_t         cmd_q  [Q_DEPTH];
  logic [IDX_W-1:0] base_q [Q_DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;

  logic             accept;
  logic             is_tick;
  logic             wr_ok;
  logic             push;
  bam_cmd_t         cmd_in;
  logic [IDX_W-1:0] base_in;

  assign in_stall = (count == 2'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (action == ACT_TICK);
  assign wr_ok    = (IDX_W'(byte_index) < IDX_W'(PLANE_BYTES));
  assign push     = accept && (is_tick || wr_ok);

  always_comb begin
    cmd_in.is_tick  = is_tick;
    cmd_in.plane    = is_tick ? bam_pick_plane(slot_count) : plane;
    cmd_in.wr_index = byte_index;
    cmd_in.wr_value = byte_value;
    cmd_in.onehot   = (int'(layer_count) < 4) ? (4'd1 << layer_count) : 4'd0;
    base_in         = IDX_W'(IDX_W'(layer_count) * IDX_W'(BYTES_PER_LAYER_N));
  end

  // Advance the refresh counters as each tick goes in.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
      slot_count  <= 4'd1;
    end else if (accept && is_tick) begin
      layer_count <= (layer_count == LAYER_W'(LAYERS - 1)) ? '0 : layer_count + 1'b1;
      slot_count  <= (slot_count == 4'(SLOT_WRAP - 1)) ? 4'd1 : slot_count + 4'd1;
    end
  end

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr]  <= cmd_in;
      base_q[wr_ptr] <= base_in;
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_cmd   = cmd_q[rd_ptr];
  assign q_base  = base_q[rd_ptr];

endmodule

### rtl/bam_back.sv
// ----------------------------------------------------------------------------
// LED cube layer multiplexer: back end
// Holds the bit-plane store, applies writes and walks each tick's bytes into
// the output register, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bam_back
  import bam_pkg::*;
#(
  parameter int BYTES_PER_LAYER_N = BYTES_PER_LAYER_N_DEF,
  parameter int IDX_W             = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bam_cmd_t         q_cmd,
  input  logic [IDX_W-1:0] q_base,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       shift_byte,
  output logic [3:0]       layer_onehot,
  output logic [1:0]       shown_plane,
  output logic             last
);

  localparam int CNT_W = (BYTES_PER_LAYER_N > 1) ? $clog2(BYTES_PER_LAYER_N) : 1;

  bam_back_state_t state;
  bam_back_state_t state_next;
  logic [CNT_W-1:0] byte_cnt;
  logic [CNT_W-1:0] byte_cnt_next;

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld;

  logic                  out_free;
  logic                  load;
  logic                  mem_we;
  logic                  is_last;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_in;
  logic [MEM_ADDR_W-1:0] rd_addr;
  logic [MEM_ADDR_W-1:0] wr_addr;

  assign out_free = !out_valid || !out_stall;
  assign is_last  = (byte_cnt == CNT_W'(BYTES_PER_LAYER_N - 1));
  assign rd_idx   = q_base + IDX_W'(byte_cnt);
  assign rd_in    = (rd_idx < IDX_W'(STORE_BYTES));
  assign rd_addr  = {q_cmd.plane, rd_idx[2:0]};
  assign wr_addr  = {q_cmd.plane, q_cmd.wr_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      byte_cnt <= '0;
    end else begin
      state    <= state_next;
      byte_cnt <= byte_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    byte_cnt_next = byte_cnt;
    load          = 1'b0;
    mem_we        = 1'b0;
    q_pop         = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (q_cmd.is_tick) begin
            state_next    = B_TICK;
            byte_cnt_next = '0;
          end else begin
            mem_we = 1'b1;
            q_pop  = 1'b1;
          end
        end
      end
      B_TICK: begin
        // Hold the tick at the queue head until its last byte is loaded.
        if (out_free) begin
          load = 1'b1;
          if (is_last) begin
            q_pop      = 1'b1;
            state_next = B_IDLE;
          end else begin
            byte_cnt_next = byte_cnt + 1'b1;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_cmd.wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[wr_addr] <= 1'b1;
    end
  end

  // Unwritten bytes and bytes past the store read as zero.
  always_ff @(posedge clk) begin
    if (load) begin
      shift_byte   <= (rd_in && mem_vld[rd_addr]) ? mem[rd_addr] : 8'd0;
      layer_onehot <= q_cmd.onehot;
      shown_plane  <= q_cmd.plane;
      last         <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/bam_layer_multiplexer_checker.sv
// ----------------------------------------------------------------------------
// LED cube layer multiplexer: port checker
// Watches the top-level ports for output ordering and reset behavior.
// ----------------------------------------------------------------------------
`include "bam_layer_multiplexer_macros.svh"

module bam_layer_multiplexer_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] shift_byte,
  input logic [3:0] layer_onehot,
  input logic [1:0] shown_plane,
  input logic       last
);

  `BAM_ASSERT_RESET(a_reset_empty, !out_valid, "output valid right after reset")

  `BAM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(shift_byte) && $stable(last),
                   "stalled output changed")

  `BAM_ASSERT_SAME(a_onehot, out_valid, $onehot0(layer_onehot), "layer select not one-hot")

  `BAM_ASSERT_NEXT(a_tick_burst, out_valid && !out_stall && !last,
                   out_valid && $stable(layer_onehot) && $stable(shown_plane),
                   "tick bytes not back to back")

endmodule

bind bam_layer_multiplexer bam_layer_multiplexer_checker u_checker (.*);

### verif/bam_layer_multiplexer_test.sv
// ----------------------------------------------------------------------------
// LED cube layer multiplexer: testbench
// Streams frame byte writes and refresh ticks into the block with random gaps
// and output backpressure, predicts every shifted column byte, and checks the
// block's output stream in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bam_layer_multiplexer_test;
  import bam_pkg::*;

  localparam int PLANE_BYTES    = LAYERS_DEF * BYTES_PER_LAYER_N_DEF;
  localparam int RANDOM_ITEMS   = 1225;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    bam_action_t act;
    logic [1:0]  pl;
    logic [2:0]  idx;
    logic [7:0]  val;
  } cube_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] sel;
    logic [1:0] pl;
    logic       lst;
  } column_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = 1'b0;
  logic [1:0] plane = 2'd0;
  logic [2:0] byte_index = 3'd0;
  logic [7:0] byte_value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] shift_byte;
  logic [3:0] layer_onehot;
  logic [1:0] shown_plane;
  logic       last;

  cube_item_t   pending_items[$];
  column_byte_t expected_bytes[$];

  // Predicted block state
  logic [7:0] plane_mem [PLANE_COUNT][PLANE_BYTES];
  int         cur_layer;
  int         cur_slot;

  cube_item_t staged;
  logic       staged_ok = 1'b0;
  int         tx_gap = 0;
  logic       tx_steady = 1'b0;
  int         rx_wait = 0;
  logic       rx_steady = 1'b0;
  logic       hold_off = 1'b0;

  int items_taken = 0;
  int writes_seen = 0;
  int ticks_seen = 0;
  int slot_wraps = 0;
  int bytes_checked = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  bam_layer_multiplexer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .plane        (plane),
    .byte_index   (byte_index),
    .byte_value   (byte_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .shift_byte   (shift_byte),
    .layer_onehot (layer_onehot),
    .shown_plane  (shown_plane),
    .last         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Store a frame byte, or work out the column bytes a refresh tick shifts.
  task automatic predict_item(input cube_item_t it);
    logic [1:0]   pick;
    logic [3:0]   sel;
    int           pos;
    column_byte_t r;
    if (it.act == ACT_WRITE) begin
      writes_seen++;
      if (int'(it.idx) < PLANE_BYTES) plane_mem[it.pl][it.idx] = it.val;
    end else begin
      ticks_seen++;
      if (cur_slot >= 8) begin
        pick = 2'd3;
      end else if (cur_slot >= 4) begin
        pick = 2'd2;
      end else if (cur_slot >= 2) begin
        pick = 2'd1;
      end else begin
        pick = 2'd0;
      end
      sel = (cur_layer < 4) ? 4'(1 << cur_layer) : 4'd0;
      for (int i = 0; i < BYTES_PER_LAYER_N_DEF; i++) begin
        pos = cur_layer * BYTES_PER_LAYER_N_DEF + i;
        r.data = (pos < PLANE_BYTES) ? plane_mem[pick][pos] : 8'd0;
        r.sel = sel;
        r.pl = pick;
        r.lst = (i == BYTES_PER_LAYER_N_DEF - 1);
        expected_bytes.push_back(r);
      end
      if (cur_slot + 1 >= SLOT_WRAP_DEF) begin
        cur_slot = 1;
        slot_wraps++;
      end else begin
        cur_slot = cur_slot + 1;
      end
      cur_layer = (cur_layer + 1 >= LAYERS_DEF) ? 0 : cur_layer + 1;
    end
  endtask

  // Driver: hold each item until taken, then wait its drawn gap before the next.
  always @(posedge clk) begin
    logic next_valid;
    if (!rst) begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_item(staged);
        items_taken++;
        if (items_taken % 64 == 0) tx_steady = ($urandom_range(0, 2) == 0);
        next_valid = 1'b0;
        staged_ok = 1'b0;
      end
      if (!staged_ok && pending_items.size() != 0) begin
        staged = pending_items.pop_front();
        staged_ok = 1'b1;
        tx_gap = tx_steady ? 0 : $urandom_range(0, 10);
      end
      if (staged_ok && !next_valid) begin
        if (tx_gap == 0) begin
          action <= staged.act;
          plane <= staged.pl;
          byte_index <= staged.idx;
          byte_value <= staged.val;
          next_valid = 1'b1;
        end else begin
          tx_gap--;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: check each taken byte against the oldest prediction, then draw a stall, none in steady spells.
  always @(posedge clk) begin
    column_byte_t seen;
    column_byte_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = '{shift_byte, layer_onehot, shown_plane, last};
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: unexpected byte %h sel %b plane %0d last %b",
                     seen.data, seen.sel, seen.pl, seen.lst);
        end else begin
          want = expected_bytes.pop_front();
          if (seen.data !== want.data || seen.sel !== want.sel ||
              seen.pl !== want.pl || seen.lst !== want.lst) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("ERROR: byte %0d expected %h/%b/%0d/%b got %h/%b/%0d/%b",
                       bytes_checked, want.data, want.sel, want.pl, want.lst,
                       seen.data, seen.sel, seen.pl, seen.lst);
          end
        end
        if (bytes_checked % 64 == 0) rx_steady = ($urandom_range(0, 2) == 0);
        rx_wait = rx_steady ? 0 : $urandom_range(0, 10);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= hold_off || (rx_wait != 0);
    end
  end

  // Long output hold-off while the sender keeps offering items.
  initial begin
    wait (items_taken >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    cube_item_t it;
    foreach (plane_mem[p, b]) plane_mem[p][b] = 8'd0;
    cur_layer = 0;
    cur_slot = 1;

    // Tick straight after reset shows the cleared store.
    pending_items.push_back('{ACT_TICK, 2'd0, 3'd0, 8'd0});
    pending_items.push_back('{ACT_WRITE, 2'd0, 3'd0, 8'hFF});
    pending_items.push_back('{ACT_WRITE, 2'd3, 3'd7, 8'hFF});
    pending_items.push_back('{ACT_WRITE, 2'd1, 3'd3, 8'hA5});
    pending_items.push_back('{ACT_WRITE, 2'd2, 3'd4, 8'h5A});
    pending_items.push_back('{ACT_WRITE, 2'd0, 3'd1, 8'h80});
    pending_items.push_back('{ACT_WRITE, 2'd3, 3'd6, 8'h01});
    // Run the slot counter through every weight and back to slot one.
    repeat (16) pending_items.push_back('{ACT_TICK, 2'd3, 3'd7, 8'hFF});

    repeat (RANDOM_ITEMS) begin
      it.act = ($urandom_range(0, 99) < 50) ? ACT_WRITE : ACT_TICK;
      it.pl = 2'($urandom_range(0, 3));
      it.idx = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0: it.val = 8'h00;
        1: it.val = 8'hFF;
        default: it.val = 8'($urandom_range(0, 255));
      endcase
      pending_items.push_back(it);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || staged_ok || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += expected_bytes.size();

    $display("Covered %0d frame writes and %0d refresh ticks; %0d column bytes checked.",
             writes_seen, ticks_seen, bytes_checked);
    $display("Slot counter wrapped %0d times; output held off %0d cycles once.",
             slot_wraps, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
